/* rtl/core/fspc_pkg.sv */
package fspc_pkg;

    localparam int ADDR_W = 12;
    localparam int DATA_W = 32;
    localparam int WORD_W = 25;
    localparam int REG_W  = 3;
    localparam int REG_COUNT = 8;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [REG_W-1:0]  t_reg;
    typedef logic [2:0]        t_op;

    localparam t_op OP_ADD  = 3'd0;
    localparam t_op OP_NOR  = 3'd1;
    localparam t_op OP_LW   = 3'd2;
    localparam t_op OP_SW   = 3'd3;
    localparam t_op OP_BEQ  = 3'd4;
    localparam t_op OP_JALR = 3'd5;
    localparam t_op OP_HALT = 3'd6;
    localparam t_op OP_NOOP = 3'd7;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam t_word NOOP_WORD = 25'h1c00000;

    typedef struct packed {
        logic              halted;
        logic [ADDR_W-1:0] fetch_address;
        logic              reg_write_valid;
        t_reg              reg_write_index;
        logic [DATA_W-1:0] reg_write_value;
        logic              store_valid;
        logic [ADDR_W-1:0] store_address;
        logic [DATA_W-1:0] store_value;
        logic [DATA_W-1:0] cycle_count;
    } t_result;

    function automatic t_op op_of(t_word w);
        return w[24:22];
    endfunction

    function automatic t_reg ra_of(t_word w);
        return w[21:19];
    endfunction

    function automatic t_reg rb_of(t_word w);
        return w[18:16];
    endfunction

    // destination register of a word, zero when it writes none
    function automatic t_reg dest_of(t_word w);
        t_reg d;
        d = '0;
        case (w[24:22])
            OP_ADD, OP_NOR: d = w[2:0];
            OP_LW:          d = w[18:16];
            default:        d = '0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/fspc_if.sv */
interface fspc_in_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic [fspc_pkg::ADDR_W-1:0]        load_address;
    logic signed [fspc_pkg::DATA_W-1:0] load_word;

    modport source (output valid, output opcode, output load_address, output load_word,
                    input ready);
    modport sink (input valid, input opcode, input load_address, input load_word,
                  output ready);
endinterface

interface fspc_out_if;
    logic                               valid;
    logic                               ready;
    logic                               halted;
    logic [fspc_pkg::ADDR_W-1:0]        fetch_address;
    logic                               reg_write_valid;
    logic [fspc_pkg::REG_W-1:0]         reg_write_index;
    logic signed [fspc_pkg::DATA_W-1:0] reg_write_value;
    logic                               store_valid;
    logic [fspc_pkg::ADDR_W-1:0]        store_address;
    logic signed [fspc_pkg::DATA_W-1:0] store_value;
    logic [fspc_pkg::DATA_W-1:0]        cycle_count;

    modport source (output valid, output halted, output fetch_address,
                    output reg_write_valid, output reg_write_index, output reg_write_value,
                    output store_valid, output store_address, output store_value,
                    output cycle_count, input ready);
    modport sink (input valid, input halted, input fetch_address,
                  input reg_write_valid, input reg_write_index, input reg_write_value,
                  input store_valid, input store_address, input store_value,
                  input cycle_count, output ready);
endinterface

/* rtl/core/five_stage_pipeline_core.sv */
// The result word of an accepted word is registered and shown in the cycle after it is accepted.
// Throughput: one word per cycle while the result word is taken; pipeline state and both
// memories update then; memory and register file reads are prefetched into registers.
// Reset (synchronous, active low): pc, register file, pipeline registers and cycle count
// clear, pipeline words hold the noop; memory contents are kept and undefined until loaded.
// MEM_WORDS must be a power of two.
module five_stage_pipeline_core #(
    parameter int MEM_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fspc_in_if.sink     i_in,
    fspc_out_if.source  o_out
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int DW = fspc_pkg::DATA_W;

    typedef logic [AW-1:0] t_addr;

    // memories and register file
    logic [DW-1:0] r_imem [MEM_WORDS];
    logic [DW-1:0] r_dmem [MEM_WORDS];
    logic [DW-1:0] r_rf   [fspc_pkg::REG_COUNT];

    // pipeline state
    t_addr                 r_pc;
    fspc_pkg::t_word       r_fd_word, r_de_word, r_em_word, r_mw_word, r_we_word;
    t_addr                 r_fd_npc, r_de_npc, r_em_target;
    logic [DW-1:0]         r_de_a, r_de_b, r_em_alu, r_em_store, r_mw_data, r_we_data;
    logic [15:0]           r_de_off;
    logic [DW-1:0]         r_cycles;

    // prefetched reads
    logic [DW-1:0]         r_imem_q, r_dmem_q, r_rfa_q, r_rfb_q;

    // result register
    logic                  r_ovalid;
    fspc_pkg::t_result     r_res;

    logic                  acc, step, halted;
    fspc_pkg::t_result     n_res;

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;
    assign halted     = fspc_pkg::op_of(r_mw_word) == fspc_pkg::OP_HALT;
    assign step       = acc && i_in.opcode == fspc_pkg::CMD_STEP && !halted;

    // next-state logic
    t_addr           n_pc, n_fd_npc, n_de_npc, n_em_target;
    fspc_pkg::t_word n_fd_word, n_de_word, n_em_word;
    logic [DW-1:0]   n_de_a, n_de_b, n_em_alu, n_em_store, n_mw_data;
    logic [15:0]     n_de_off;
    logic [DW-1:0]   fa, fb, second, alu;
    logic            stall, taken, sw_we;
    t_addr           em_addr, ld_addr;
    fspc_pkg::t_op   eop, mop;
    fspc_pkg::t_reg  wd;

    function automatic logic [DW-1:0] fwd(fspc_pkg::t_reg r, logic [DW-1:0] dflt,
                                          fspc_pkg::t_word em, logic [DW-1:0] em_alu,
                                          fspc_pkg::t_word mw, logic [DW-1:0] mw_d,
                                          fspc_pkg::t_word we, logic [DW-1:0] we_d);
        logic [DW-1:0] v;
        v = dflt;
        if (r == '0) begin
            v = dflt;
        end else if ((fspc_pkg::op_of(em) == fspc_pkg::OP_ADD ||
                      fspc_pkg::op_of(em) == fspc_pkg::OP_NOR) && em[2:0] == r) begin
            v = em_alu;
        end else if (fspc_pkg::dest_of(mw) == r) begin
            v = mw_d;
        end else if (fspc_pkg::dest_of(we) == r) begin
            v = we_d;
        end
        return v;
    endfunction

    always_comb begin
        ld_addr  = AW'(i_in.load_address);
        em_addr  = r_em_alu[AW-1:0];
        mop      = fspc_pkg::op_of(r_em_word);
        eop      = fspc_pkg::op_of(r_de_word);
        wd       = fspc_pkg::dest_of(r_mw_word);

        // fetch
        n_fd_word = r_imem_q[fspc_pkg::WORD_W-1:0];
        n_fd_npc  = r_pc + 1'b1;
        n_pc      = r_pc + 1'b1;

        // decode, with load-use stall
        n_de_word = r_fd_word;
        n_de_npc  = r_fd_npc;
        n_de_a    = r_rfa_q;
        n_de_b    = r_rfb_q;
        n_de_off  = r_fd_word[15:0];
        stall = eop == fspc_pkg::OP_LW &&
                (fspc_pkg::rb_of(r_de_word) == fspc_pkg::ra_of(r_fd_word) ||
                 fspc_pkg::rb_of(r_de_word) == fspc_pkg::rb_of(r_fd_word));
        if (stall) begin
            n_de_word = fspc_pkg::NOOP_WORD;
            n_de_npc  = '0;
            n_de_a    = '0;
            n_de_b    = '0;
            n_de_off  = '0;
            n_pc      = r_pc;
            n_fd_word = r_fd_word;
            n_fd_npc  = r_fd_npc;
        end

        // execute
        fa = fwd(fspc_pkg::ra_of(r_de_word), r_de_a, r_em_word, r_em_alu,
                 r_mw_word, r_mw_data, r_we_word, r_we_data);
        fb = fwd(fspc_pkg::rb_of(r_de_word), r_de_b, r_em_word, r_em_alu,
                 r_mw_word, r_mw_data, r_we_word, r_we_data);
        second = (eop == fspc_pkg::OP_LW || eop == fspc_pkg::OP_SW) ?
                 {{(DW-16){r_de_off[15]}}, r_de_off} : fb;
        case (eop)
            fspc_pkg::OP_ADD, fspc_pkg::OP_LW, fspc_pkg::OP_SW: alu = fa + second;
            fspc_pkg::OP_NOR: alu = ~(fa | second);
            fspc_pkg::OP_BEQ: alu = fa - second;
            default:          alu = '0;
        endcase
        n_em_word   = r_de_word;
        n_em_alu    = alu;
        n_em_store  = fb;
        n_em_target = r_de_npc + AW'({{(DW-16){r_de_off[15]}}, r_de_off});

        // memory stage
        n_mw_data = '0;
        sw_we     = 1'b0;
        taken     = 1'b0;
        case (mop)
            fspc_pkg::OP_ADD, fspc_pkg::OP_NOR: n_mw_data = r_em_alu;
            fspc_pkg::OP_LW:  n_mw_data = r_dmem_q;
            fspc_pkg::OP_SW:  sw_we = 1'b1;
            fspc_pkg::OP_BEQ: taken = r_em_alu == '0;
            default:          n_mw_data = '0;
        endcase
        // squash the three younger words on a taken branch
        if (taken) begin
            n_pc        = r_em_target;
            n_fd_word   = fspc_pkg::NOOP_WORD;
            n_fd_npc    = '0;
            n_de_word   = fspc_pkg::NOOP_WORD;
            n_de_npc    = '0;
            n_de_a      = '0;
            n_de_b      = '0;
            n_de_off    = '0;
            n_em_word   = fspc_pkg::NOOP_WORD;
            n_em_target = '0;
            n_em_alu    = '0;
            n_em_store  = '0;
        end

        // result word
        n_res                 = '0;
        n_res.halted          = halted;
        n_res.fetch_address   = fspc_pkg::ADDR_W'(r_pc);
        n_res.cycle_count     = r_cycles;
        if (step) begin
            n_res.halted        = 1'b0;
            n_res.fetch_address = fspc_pkg::ADDR_W'(n_pc);
            n_res.cycle_count   = r_cycles + {{(DW-1){1'b0}}, r_cycles != '1};
            if (wd != '0) begin
                n_res.reg_write_valid = 1'b1;
                n_res.reg_write_index = wd;
                n_res.reg_write_value = r_mw_data;
            end
            if (sw_we) begin
                n_res.store_valid   = 1'b1;
                n_res.store_address = fspc_pkg::ADDR_W'(em_addr);
                n_res.store_value   = r_em_store;
            end
        end
    end

    // pipeline registers: advance on a step word only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_fd_word   <= fspc_pkg::NOOP_WORD;
            r_de_word   <= fspc_pkg::NOOP_WORD;
            r_em_word   <= fspc_pkg::NOOP_WORD;
            r_mw_word   <= fspc_pkg::NOOP_WORD;
            r_we_word   <= fspc_pkg::NOOP_WORD;
            r_fd_npc    <= '0;
            r_de_npc    <= '0;
            r_em_target <= '0;
            r_de_a      <= '0;
            r_de_b      <= '0;
            r_de_off    <= '0;
            r_em_alu    <= '0;
            r_em_store  <= '0;
            r_mw_data   <= '0;
            r_we_data   <= '0;
            r_cycles    <= '0;
        end else if (step) begin
            r_pc        <= n_pc;
            r_fd_word   <= n_fd_word;
            r_fd_npc    <= n_fd_npc;
            r_de_word   <= n_de_word;
            r_de_npc    <= n_de_npc;
            r_de_a      <= n_de_a;
            r_de_b      <= n_de_b;
            r_de_off    <= n_de_off;
            r_em_word   <= n_em_word;
            r_em_target <= n_em_target;
            r_em_alu    <= n_em_alu;
            r_em_store  <= n_em_store;
            r_mw_word   <= r_em_word;
            r_mw_data   <= n_mw_data;
            r_we_word   <= r_mw_word;
            r_we_data   <= r_mw_data;
            r_cycles    <= n_res.cycle_count;
        end
    end

    // register file: write back, r0 never written; prefetch decode operands
    fspc_pkg::t_word rf_word;
    logic            rf_we;
    assign rf_word = step ? n_fd_word : r_fd_word;
    assign rf_we   = step && wd != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fspc_pkg::REG_COUNT; k++) begin
                r_rf[k] <= '0;
            end
            r_rfa_q <= '0;
            r_rfb_q <= '0;
        end else begin
            if (rf_we) begin
                r_rf[wd] <= r_mw_data;
            end
            r_rfa_q <= (rf_we && wd == fspc_pkg::ra_of(rf_word)) ?
                       r_mw_data : r_rf[fspc_pkg::ra_of(rf_word)];
            r_rfb_q <= (rf_we && wd == fspc_pkg::rb_of(rf_word)) ?
                       r_mw_data : r_rf[fspc_pkg::rb_of(rf_word)];
        end
    end

    // instruction memory: load writes, prefetch at the next pc
    logic  im_we;
    t_addr im_raddr;
    assign im_we    = acc && i_in.opcode == fspc_pkg::CMD_LOAD;
    assign im_raddr = step ? n_pc : r_pc;

    always_ff @(posedge i_clk) begin
        if (im_we) begin
            r_imem[ld_addr] <= DW'(i_in.load_word);
        end
        r_imem_q <= (im_we && ld_addr == im_raddr) ? DW'(i_in.load_word) : r_imem[im_raddr];
    end

    // data memory: load or sw writes, prefetch at the next lw address
    logic          dm_we;
    t_addr         dm_waddr, dm_raddr;
    logic [DW-1:0] dm_wdata;
    assign dm_we    = im_we || (step && sw_we);
    assign dm_waddr = im_we ? ld_addr : em_addr;
    assign dm_wdata = im_we ? DW'(i_in.load_word) : r_em_store;
    assign dm_raddr = step ? n_em_alu[AW-1:0] : em_addr;

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[dm_waddr] <= dm_wdata;
        end
        r_dmem_q <= (dm_we && dm_waddr == dm_raddr) ? dm_wdata : r_dmem[dm_raddr];
    end

    // result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (acc) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.halted          = r_res.halted;
    assign o_out.fetch_address   = r_res.fetch_address;
    assign o_out.reg_write_valid = r_res.reg_write_valid;
    assign o_out.reg_write_index = r_res.reg_write_index;
    assign o_out.reg_write_value = signed'(r_res.reg_write_value);
    assign o_out.store_valid     = r_res.store_valid;
    assign o_out.store_address   = r_res.store_address;
    assign o_out.store_value     = signed'(r_res.store_value);
    assign o_out.cycle_count     = r_res.cycle_count;

endmodule

/* tb/fspc_checker.sv */
module fspc_checker
    import fspc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fspc_in_if   i_in,
    fspc_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEMSZ = 4096;
    localparam logic [31:0] NOP32 = 32'h01c00000;

    // machine state as the core should hold it
    logic [31:0] imem [MEMSZ];
    logic [31:0] dmem [MEMSZ];
    logic [31:0] regs [REG_COUNT];
    logic [31:0] pc, cycles;
    logic [31:0] fd_w, fd_npc;
    logic [31:0] de_w, de_npc, de_a, de_b, de_off;
    logic [31:0] em_w, em_tgt, em_alu, em_st;
    logic [31:0] mw_w, mw_d, we_w, we_d;

    t_result expected_words[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_words.size();

    function automatic t_op opc(logic [31:0] w);
        return w[24:22];
    endfunction

    function automatic t_reg written_reg(logic [31:0] w);
        if (w[24:22] == OP_ADD || w[24:22] == OP_NOR) return w[2:0];
        if (w[24:22] == OP_LW) return w[18:16];
        return '0;
    endfunction

    // pick the youngest in-flight value for a source register
    function automatic logic [31:0] bypass(t_reg r, logic [31:0] dflt);
        if (r == 0) return dflt;
        if ((opc(em_w) == OP_ADD || opc(em_w) == OP_NOR) && em_w[2:0] == r) return em_alu;
        if (written_reg(mw_w) == r) return mw_d;
        if (written_reg(we_w) == r) return we_d;
        return dflt;
    endfunction

    task automatic clear_pipeline();
        pc = 0; cycles = 0;
        foreach (regs[i]) regs[i] = 0;
        fd_w = NOP32; fd_npc = 0;
        de_w = NOP32; de_npc = 0; de_a = 0; de_b = 0; de_off = 0;
        em_w = NOP32; em_tgt = 0; em_alu = 0; em_st = 0;
        mw_w = NOP32; mw_d = 0; we_w = NOP32; we_d = 0;
    endtask

    // advance the machine by one word and produce the expected result word
    task automatic run_word(logic cmd, logic [11:0] addr, logic [31:0] data, output t_result r);
        logic [31:0] n_pc, n_fw, n_fnpc, n_dw, n_dnpc, n_a, n_b, n_off;
        logic [31:0] n_ew, n_etgt, n_ealu, n_est, n_mw, n_md;
        logic [31:0] a, b, second, alu;
        t_reg wd;
        logic taken;
        r = '0;
        if (cmd == CMD_LOAD || opc(mw_w) == OP_HALT) begin
            if (cmd == CMD_LOAD) begin
                imem[addr] = data;
                dmem[addr] = data;
            end
            r.halted = (opc(mw_w) == OP_HALT);
            r.fetch_address = pc[11:0];
            r.cycle_count = cycles;
            return;
        end
        // fetch
        n_fw = imem[pc[11:0]];
        n_fnpc = pc + 1;
        n_pc = {20'd0, n_fnpc[11:0]};
        // decode, with load-use hold
        n_dw = fd_w; n_dnpc = fd_npc;
        n_a = regs[fd_w[21:19]];
        n_b = regs[fd_w[18:16]];
        n_off = {{16{fd_w[15]}}, fd_w[15:0]};
        if (opc(de_w) == OP_LW && (de_w[18:16] == fd_w[21:19] || de_w[18:16] == fd_w[18:16]))
        begin
            n_dw = NOP32; n_dnpc = 0; n_a = 0; n_b = 0; n_off = 0;
            n_pc = pc; n_fw = fd_w; n_fnpc = fd_npc;
        end
        // execute
        a = bypass(de_w[21:19], de_a);
        b = bypass(de_w[18:16], de_b);
        second = (opc(de_w) == OP_LW || opc(de_w) == OP_SW) ? de_off : b;
        case (opc(de_w))
            OP_ADD, OP_LW, OP_SW: alu = a + second;
            OP_NOR:               alu = ~(a | second);
            OP_BEQ:               alu = a - second;
            default:              alu = 0;
        endcase
        n_ew = de_w; n_ealu = alu; n_est = b; n_etgt = de_npc + de_off;
        // memory
        n_mw = em_w; n_md = 0; taken = 0;
        case (opc(em_w))
            OP_ADD, OP_NOR: n_md = em_alu;
            OP_LW:          n_md = dmem[em_alu[11:0]];
            OP_SW: begin
                dmem[em_alu[11:0]] = em_st;
                r.store_valid = 1;
                r.store_address = em_alu[11:0];
                r.store_value = em_st;
            end
            OP_BEQ:         taken = (em_alu == 0);
            default: ;
        endcase
        // squash the three younger words on a taken branch
        if (taken) begin
            n_pc = {20'd0, em_tgt[11:0]};
            n_fw = NOP32; n_fnpc = 0;
            n_dw = NOP32; n_dnpc = 0; n_a = 0; n_b = 0; n_off = 0;
            n_ew = NOP32; n_etgt = 0; n_ealu = 0; n_est = 0;
        end
        // writeback
        wd = written_reg(mw_w);
        if (wd != 0) begin
            regs[wd] = mw_d;
            r.reg_write_valid = 1;
            r.reg_write_index = wd;
            r.reg_write_value = mw_d;
        end
        we_w = mw_w; we_d = mw_d;
        mw_w = n_mw; mw_d = n_md;
        em_w = n_ew; em_tgt = n_etgt; em_alu = n_ealu; em_st = n_est;
        de_w = n_dw; de_npc = n_dnpc; de_a = n_a; de_b = n_b; de_off = n_off;
        fd_w = n_fw; fd_npc = n_fnpc;
        pc = n_pc;
        if (cycles != 32'hFFFFFFFF) cycles = cycles + 1;
        r.fetch_address = pc[11:0];
        r.cycle_count = cycles;
    endtask

    initial begin
        fails = 0;
        clear_pipeline();
    end

    // watch both channels: check result words, then predict for new input words
    always @(posedge i_clk) begin
        t_result got, exp, pred;
        if (!i_rst_n) begin
            clear_pipeline();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.halted          = i_out.halted;
                got.fetch_address   = i_out.fetch_address;
                got.reg_write_valid = i_out.reg_write_valid;
                got.reg_write_index = i_out.reg_write_index;
                got.reg_write_value = i_out.reg_write_value;
                got.store_valid     = i_out.store_valid;
                got.store_address   = i_out.store_address;
                got.store_value     = i_out.store_value;
                got.cycle_count     = i_out.cycle_count;
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result word %p", got);
                end else begin
                    exp = expected_words.pop_front();
                    if (got.halted !== exp.halted || got.fetch_address !== exp.fetch_address
                        || got.reg_write_valid !== exp.reg_write_valid
                        || got.reg_write_index !== exp.reg_write_index
                        || got.reg_write_value !== exp.reg_write_value
                        || got.store_valid !== exp.store_valid
                        || got.store_address !== exp.store_address
                        || got.store_value !== exp.store_value
                        || got.cycle_count !== exp.cycle_count) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %p got %p", exp, got);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                run_word(i_in.opcode, i_in.load_address, i_in.load_word, pred);
                expected_words.push_back(pred);
            end
        end
    end
endmodule

/* tb/tb.sv */
module tb;
    import fspc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOOP_END = 60;   // loop-back branch, later the halt
    localparam int RAND_WORDS = 600;

    logic clk = 0;
    logic rst_n = 0;
    int fail_count, pending;
    int cycle_ctr = 0;
    logic burst;

    fspc_in_if  in_ch();
    fspc_out_if out_ch();

    five_stage_pipeline_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    fspc_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 clk = ~clk;

    // give up on a hung run
    always @(posedge clk) begin
        cycle_ctr <= cycle_ctr + 1;
        if (cycle_ctr > 200000) begin
            $display("five_stage_pipeline_core regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] encode(t_op op, int ra, int rb, logic [15:0] off);
        logic [6:0] top_bits;
        top_bits = 7'($urandom_range(0, 127));
        return {top_bits, op, ra[2:0], rb[2:0], off};
    endfunction

    function automatic logic [15:0] data_offset();
        if ($urandom_range(0, 1)) return 16'(64 + $urandom_range(0, 31));
        return 16'(-1 - $urandom_range(0, 31));
    endfunction

    // random instruction for a body slot; branches only jump forward
    function automatic logic [31:0] body_instr(int a);
        int pick, ra, rb;
        logic [15:0] off;
        pick = $urandom_range(0, 99);
        ra = $urandom_range(0, 7);
        rb = $urandom_range(0, 7);
        off = 16'($urandom_range(0, 65535));
        if (pick < 35) return encode(pick < 18 ? OP_ADD : OP_NOR, ra, rb, off);
        if (pick < 55) return encode(OP_LW, 0, rb, data_offset());
        if (pick < 65) return encode(OP_SW, 0, rb, data_offset());
        if (pick < 82) begin
            if ($urandom_range(0, 1)) rb = ra;
            return encode(OP_BEQ, ra, rb, 16'($urandom_range(0, LOOP_END - 1 - a)));
        end
        if (pick < 90) return encode(OP_JALR, ra, rb, off);
        return encode(OP_NOOP, ra, rb, off);
    endfunction

    task automatic send_word(logic cmd, int addr, logic [31:0] data);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.opcode <= cmd;
        in_ch.load_address <= 12'(addr);
        in_ch.load_word <= data;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic step_word();
        send_word(CMD_STEP, $urandom_range(0, 4095), $urandom);
    endtask

    // drain side: random stalls, one long hold-off
    initial begin
        int taken_words, gap;
        taken_words = 0;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 3);
            if (taken_words == 300) gap = 200;
            if (gap > 0) begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1;
            do @(posedge clk); while (!out_ch.valid);
            taken_words++;
        end
    end

    initial begin
        int pick, a;
        burst = 0;
        in_ch.valid = 0;
        in_ch.opcode = CMD_LOAD;
        in_ch.load_address = 0;
        in_ch.load_word = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // data words, the extremes among them
        send_word(CMD_LOAD, 64, 32'h7FFFFFFF);
        send_word(CMD_LOAD, 65, 32'h0);
        send_word(CMD_LOAD, 4095, 32'h80000000);
        for (int i = 66; i < 96; i++) send_word(CMD_LOAD, i, $urandom);
        for (int i = 4064; i < 4095; i++) send_word(CMD_LOAD, i, $urandom);

        // program head: load-use, bypass, store then load, taken and untaken branch
        send_word(CMD_LOAD, 0, encode(OP_LW, 0, 1, 16'd64));
        send_word(CMD_LOAD, 1, encode(OP_LW, 0, 2, 16'hFFFF));
        send_word(CMD_LOAD, 2, encode(OP_ADD, 1, 2, 16'd3));
        send_word(CMD_LOAD, 3, encode(OP_NOR, 3, 1, 16'd4));
        send_word(CMD_LOAD, 4, encode(OP_SW, 0, 4, 16'd65));
        send_word(CMD_LOAD, 5, encode(OP_LW, 0, 5, 16'd65));
        send_word(CMD_LOAD, 6, encode(OP_BEQ, 5, 5, 16'd2));
        send_word(CMD_LOAD, 7, encode(OP_ADD, 1, 1, 16'd6));
        send_word(CMD_LOAD, 8, encode(OP_ADD, 1, 1, 16'd7));
        send_word(CMD_LOAD, 9, encode(OP_ADD, 1, 1, 16'd0));
        send_word(CMD_LOAD, 10, encode(OP_JALR, 1, 2, 16'd0));
        send_word(CMD_LOAD, 11, encode(OP_NOOP, 0, 0, 16'd0));
        send_word(CMD_LOAD, 12, encode(OP_BEQ, 1, 2, 16'd1));
        for (int i = 13; i < LOOP_END; i++) send_word(CMD_LOAD, i, body_instr(i));
        send_word(CMD_LOAD, LOOP_END, encode(OP_BEQ, 0, 0, 16'(-(LOOP_END + 1))));
        for (int i = LOOP_END + 1; i < 64; i++)
            send_word(CMD_LOAD, i, encode(OP_NOOP, 0, 0, 16'd0));

        // run with random rewrites of code and data
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
            if (n == 300) begin
                in_ch.valid <= 0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                step_word();
            end else if (pick < 85) begin
                a = $urandom_range(0, LOOP_END - 1);
                send_word(CMD_LOAD, a, body_instr(a));
            end else if (pick < 93) begin
                a = $urandom_range(0, 1) ? 64 + $urandom_range(0, 31)
                                         : 4064 + $urandom_range(0, 31);
                send_word(CMD_LOAD, a, $urandom);
            end else begin
                send_word(CMD_LOAD, $urandom_range(96, 4063), $urandom);
            end
        end

        // end the program: halt at the loop-back slot, run into it, poke while halted
        burst = 0;
        send_word(CMD_LOAD, LOOP_END, encode(OP_HALT, 0, 0, 16'($urandom_range(0, 65535))));
        repeat (400) step_word();
        repeat (4) send_word(CMD_LOAD, $urandom_range(96, 4063), $urandom);
        in_ch.valid <= 0;

        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("five_stage_pipeline_core regression: pass");
        else
            $display("five_stage_pipeline_core regression: fail");
        $finish;
    end
endmodule
